// ----- src/gcdp_pkg.sv -----
package gcdp_pkg;

  // register map, word offsets
  typedef enum logic [1:0] {
    OFS_STATUS = 2'd0,
    OFS_X      = 2'd1,
    OFS_Y      = 2'd2,
    OFS_RESULT = 2'd3
  } gcdp_ofs_t;

  // access kind
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // status register bits
  localparam int STATUS_DONE_BIT  = 0;
  localparam int STATUS_READY_BIT = 1;

  // bus-side word width
  localparam int BUS_WIDTH = 32;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } gcdp_state_t;

  // controller to datapath
  typedef struct packed {
    logic access;   // input transfer taken this cycle
    logic step;     // advance the gcd engine by one step
    logic finish;   // store result, set done, load zero response
  } gcdp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic engine_done;  // one of the engine operands reached zero
  } gcdp_sts_t;

endpackage

// ----- src/gcdp_ctrl.sv -----
module gcdp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  action,
  input  gcdp_pkg::gcdp_ofs_t   word_offset,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output gcdp_pkg::gcdp_cmd_t   cmd,
  input  gcdp_pkg::gcdp_sts_t   sts
);
  import gcdp_pkg::*;

  gcdp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        acc;
  logic        is_y_wr;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign is_y_wr   = (action == ACT_WRITE) && (word_offset == OFS_Y);

  always_comb begin
    cmd.access = acc;
    cmd.step   = (state_r == ST_BUSY) && !sts.engine_done;
    cmd.finish = (state_r == ST_BUSY) && sts.engine_done && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && is_y_wr) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (cmd.finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((acc && !is_y_wr) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- src/gcdp_datapath.sv -----
module gcdp_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcdp_pkg::gcdp_cmd_t               cmd,
  input  logic                              action,
  input  gcdp_pkg::gcdp_ofs_t               word_offset,
  input  logic [gcdp_pkg::BUS_WIDTH-1:0]    write_data,
  output gcdp_pkg::gcdp_sts_t               sts,
  output logic [gcdp_pkg::BUS_WIDTH-1:0]    read_data
);
  import gcdp_pkg::*;

  localparam int KW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [BUS_WIDTH-1:0]  rdata_r, rdata_nxt;

  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] diff;
  logic                  a_ge_b;
  logic [BUS_WIDTH-1:0]  rd;

  assign wdata  = DATA_WIDTH'(write_data);
  assign a_ge_b = a_r >= b_r;
  assign diff   = a_ge_b ? (a_r - b_r) : (b_r - a_r);

  assign sts.engine_done = (a_r == '0) || (b_r == '0);

  // read mux, zero on writes
  always_comb begin
    rd = '0;
    if (action == ACT_READ) begin
      case (word_offset)
        OFS_STATUS: begin
          rd[STATUS_DONE_BIT]  = done_r;
          rd[STATUS_READY_BIT] = 1'b1;
        end
        OFS_X:      rd = BUS_WIDTH'(x_r);
        OFS_Y:      rd = BUS_WIDTH'(y_r);
        OFS_RESULT: rd = BUS_WIDTH'(res_r);
        default:    rd = '0;
      endcase
    end
  end

  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    res_nxt   = res_r;
    done_nxt  = done_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    rdata_nxt = rdata_r;

    if (cmd.access) begin
      rdata_nxt = rd;
      if (action == ACT_WRITE) begin
        case (word_offset)
          OFS_X: x_nxt = wdata;
          OFS_Y: begin
            y_nxt = wdata;
            a_nxt = x_r;
            b_nxt = wdata;
            k_nxt = '0;
          end
          default: ;
        endcase
      end else if (word_offset == OFS_RESULT) begin
        done_nxt = 1'b0;
      end
    end

    // binary gcd step: strip common twos, then halve or subtract-and-halve
    if (cmd.step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_ge_b) begin
        a_nxt = diff >> 1;
      end else begin
        b_nxt = diff >> 1;
      end
    end

    // one operand is zero, the other holds the odd part
    if (cmd.finish) begin
      res_nxt   = (a_r | b_r) << k_r;
      done_nxt  = 1'b1;
      rdata_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      res_r  <= '0;
      done_r <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      res_r  <= res_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    rdata_r <= rdata_nxt;
  end

  assign read_data = rdata_r;

endmodule

// ----- src/gcd_register_peripheral.sv -----
// channel | direction | tdata              | tuser
// --------+-----------+--------------------+------------------------------
// in_     | slave     | [31:0] write_data  | [0] action, [2:1] word_offset
// out_    | master    | [31:0] read_data   | none
//
// each transfer on in_ gives exactly one transfer on out_, in order
// reads, and writes other than y: response registered in the cycle after the transfer
// y write: gcd runs on a binary-gcd step unit, one step per cycle,
// at most 2*DATA_WIDTH steps, then the result is stored once out_ is free; response follows
// one access is in flight at a time; in_tready is low while the gcd runs
// out_tready low with a response waiting holds the response register and stalls in_
// rst_n synchronous: clears operands, result, done flag and all valids
module gcd_register_peripheral #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] write_data
  input  logic [2:0]  in_tuser,   // [0] action, [2:1] word_offset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] read_data
);
  import gcdp_pkg::*;

  gcdp_cmd_t cmd;
  gcdp_sts_t sts;
  gcdp_ofs_t word_offset;
  logic      action;

  // access decode from the sideband
  assign action      = in_tuser[0];
  assign word_offset = gcdp_ofs_t'(in_tuser[2:1]);

  // sequencing and handshake
  gcdp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .action      (action),
    .word_offset (word_offset),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // register file, gcd engine and response register
  gcdp_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .action      (action),
    .word_offset (word_offset),
    .write_data  (in_tdata),
    .sts         (sts),
    .read_data   (out_tdata)
  );

endmodule

// ----- src/gcdp_checker.sv -----
module gcdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import gcdp_pkg::*;

  logic in_acc;
  logic is_write;
  logic is_y;
  logic is_status;

  assign in_acc    = in_tvalid && in_tready;
  assign is_write  = (in_tuser[0] == ACT_WRITE);
  assign is_y      = (in_tuser[2:1] == OFS_Y);
  assign is_status = (in_tuser[2:1] == OFS_STATUS);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response changed while stalled");

  // plain writes answer next cycle with zero
  a_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_write && !is_y |=> out_tvalid && (out_tdata == '0))
    else $error("write response missing or nonzero");

  // status read always reports ready, upper bits clear
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_write && is_status |=>
      out_tvalid && out_tdata[STATUS_READY_BIT] && (out_tdata[31:2] == '0))
    else $error("bad status response");

  // a y write starts a computation: no response and no new access next cycle
  a_y_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_write && is_y |=> !out_tvalid && !in_tready)
    else $error("y write answered or accepted too early");

  // reset empties the response register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("response valid after reset");

endmodule

bind gcd_register_peripheral gcdp_checker u_gcdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/sv/testbench.sv -----
module testbench;
  import gcdp_pkg::*;

  localparam int CLK_HALF = 5;
  // worst item: ~2*DATA_WIDTH gcd steps plus long receiver stalls, taken many times over
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE1_END = 370;
  localparam int PHASE2_END = 710;
  localparam int PHASE3_END = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;   // [31:0] write_data
  logic [2:0]  in_tuser = '0;   // [0] action, [2:1] word_offset
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;       // [31:0] read_data

  gcd_register_peripheral dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // register file as the bus sees it
  logic [31:0] shadow_x = '0;
  logic [31:0] shadow_y = '0;
  logic [31:0] shadow_gcd = '0;
  logic        shadow_done = 1'b0;

  // read data still owed by the block, oldest first
  logic [31:0] pending_read_data[$];
  logic [31:0] expected_read_data;

  int in_idle_pct = 21;
  int out_idle_pct = 61;
  int accesses_sent = 0;
  int error_count = 0;
  int cycle_count = 0;

  // euclid, with gcd(0, b) = b and gcd(a, 0) = a falling out of the loop
  function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // applies one access to the shadow registers, returns the read data it produces
  function automatic logic [31:0] apply_access(logic act, gcdp_ofs_t ofs, logic [31:0] data);
    logic [31:0] rd;
    rd = '0;
    if (act == ACT_WRITE) begin
      case (ofs)
        OFS_X: shadow_x = data;
        OFS_Y: begin
          shadow_y = data;
          shadow_gcd = gcd_of(shadow_x, data);
          shadow_done = 1'b1;
        end
        default: ;  // status and result ignore writes
      endcase
    end else begin
      case (ofs)
        OFS_STATUS: begin
          rd[STATUS_READY_BIT] = 1'b1;
          rd[STATUS_DONE_BIT] = shadow_done;
        end
        OFS_X: rd = shadow_x;
        OFS_Y: rd = shadow_y;
        OFS_RESULT: begin
          rd = shadow_gcd;
          shadow_done = 1'b0;  // reading the result clears done
        end
        default: rd = '0;
      endcase
    end
    return rd;
  endfunction

  // one access on in_, with random idle cycles ahead of it
  task automatic send_access(input logic act, input gcdp_ofs_t ofs, input logic [31:0] data);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= {ofs, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_read_data.push_back(apply_access(act, ofs, data));
    accesses_sent++;
  endtask

  task automatic write_reg(input gcdp_ofs_t ofs, input logic [31:0] data);
    send_access(ACT_WRITE, ofs, data);
  endtask

  task automatic read_reg(input gcdp_ofs_t ofs);
    send_access(ACT_READ, ofs, $urandom);  // write_data is don't-care on reads
  endtask

  // mix of corner values and plain random words
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3, 4: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_after_reset();
    read_reg(OFS_STATUS);
    read_reg(OFS_X);
    read_reg(OFS_Y);
    read_reg(OFS_RESULT);
  endtask

  // zero in either operand, and both zero
  task automatic test_zero_operands();
    write_reg(OFS_Y, '0);
    read_reg(OFS_RESULT);
    write_reg(OFS_Y, 32'd5);
    write_reg(OFS_X, 32'd7);
    write_reg(OFS_Y, '0);
    read_reg(OFS_RESULT);
  endtask

  // full-scale operands, coprime neighbors give the longest run
  task automatic test_extremes();
    write_reg(OFS_X, 32'hFFFF_FFFF);
    write_reg(OFS_Y, 32'hFFFF_FFFE);
    read_reg(OFS_RESULT);
    write_reg(OFS_Y, 32'hFFFF_FFFF);
    read_reg(OFS_X);
    read_reg(OFS_Y);
  endtask

  // writes to status and result leave everything alone
  task automatic test_ignored_writes();
    write_reg(OFS_STATUS, 32'hFFFF_FFFF);
    write_reg(OFS_RESULT, 32'hFFFF_FFFF);
    read_reg(OFS_STATUS);
    read_reg(OFS_RESULT);
  endtask

  // x write keeps done, result read clears it, back-to-back y writes recompute
  task automatic test_done_flag();
    write_reg(OFS_Y, 32'd9);
    write_reg(OFS_X, 32'd12);
    read_reg(OFS_STATUS);
    read_reg(OFS_RESULT);
    read_reg(OFS_STATUS);
    write_reg(OFS_Y, 32'd18);
    write_reg(OFS_Y, 32'd8);
    read_reg(OFS_RESULT);
  endtask

  // driver-like sequence: load operands, poll status, fetch result
  task automatic run_gcd_sequence();
    logic [31:0] x_val;
    logic [31:0] y_val;
    logic [31:0] factor;
    int polls;
    x_val = pick_operand();
    y_val = pick_operand();
    if ($urandom_range(0, 2) == 0) begin
      // shared factor so the result is not just 1
      factor = $urandom_range(2, 5000);
      x_val = factor * $urandom_range(0, 60000);
      y_val = factor * $urandom_range(0, 60000);
    end
    write_reg(OFS_X, x_val);
    write_reg(OFS_Y, y_val);
    polls = $urandom_range(0, 2);
    repeat (polls) read_reg(OFS_STATUS);
    if ($urandom_range(0, 3) == 0) read_reg($urandom_range(0, 1) ? OFS_X : OFS_Y);
    read_reg(OFS_RESULT);
    if ($urandom_range(0, 3) == 0) read_reg(OFS_STATUS);
  endtask

  task automatic test_random(input int sender_idle, input int receiver_idle, input int stop_at);
    while (accesses_sent < stop_at) begin
      in_idle_pct = sender_idle;
      out_idle_pct = receiver_idle;
      if ($urandom_range(0, 9) < 8) begin
        run_gcd_sequence();
      end else begin
        // stray access, any kind at any offset
        send_access(1'($urandom_range(0, 1)), gcdp_ofs_t'($urandom_range(0, 3)), pick_operand());
      end
    end
  endtask

  // response checker, also paces out_tready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_read_data.size() == 0) begin
          $error("unexpected transfer on out_, read_data %h", out_tdata);
          error_count++;
        end else begin
          expected_read_data = pending_read_data.pop_front();
          if (out_tdata !== expected_read_data) begin
            $error("read_data: expected %h, actual %h", expected_read_data, out_tdata);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_zero_operands();
    test_extremes();
    test_ignored_writes();
    test_done_flag();

    // sender mostly busy, receiver slow; then reversed; then full rate
    test_random(21, 61, PHASE1_END);
    test_random(61, 21, PHASE2_END);
    test_random(0, 0, PHASE3_END);

    in_tvalid <= 1'b0;
    while (pending_read_data.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
